// ----- rtl/pps_pkg.sv -----
// Package for the preemptive priority scheduler: slot entry layout, opcodes,
// sequencer states and default sizes.
// No dependencies; used by the top level of the block.
`default_nettype none

package pps_pkg;

  localparam int DEF_TASK_SLOTS = 8;

  localparam int ID_W   = 8;
  localparam int TICK_W = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // One task slot as kept in the slot memory.
  typedef struct packed {
    logic [PRIO_W-1:0]  priority_val;
    logic [BURST_W-1:0] remaining;
    logic [TICK_W-1:0]  arrival;
    logic [ID_W-1:0]    task_id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/pps_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/preemptive_priority_scheduler_unit.sv -----
// Top level of the preemptive priority scheduler.
// Depends on pps_pkg and on pps_ram for the task slot memory.
//
// Usage:
// Items enter on the s_axis channel. tuser carries the opcode: a load item
// writes its task (id, arrival tick, burst length, priority) into the next
// free slot and gives no result; it is dropped when all slots are taken.
// A tick item scans the slots and produces one result item on m_axis: the
// id of the task run (or idle), an all-done flag and the tick of the
// selection. Among arrived tasks with work left, the smallest priority
// value wins, and on a tie the slot loaded first wins.
// Sequence: a load is written straight into its slot. After a tick is accepted, the
// scan makes one read per loaded slot through the single read port, waits out the
// registered read, then leaves the scan; the final step writes back and registers
// the result, and the next item is taken once the sequencer is idle again.
// The result sits in an output register, so loads are still accepted while
// a result waits; a tick that finishes while the previous result is still
// stalled holds in its final step until the receiver takes it.
// Reset empties the table and clears the tick counter; the slot memory
// needs no clearing pass, since only slots below the load count are read.
`default_nettype none

module preemptive_priority_scheduler_unit
  import pps_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // task_id[7:0], arrival_tick[23:8], burst_length[39:24], task_priority[47:40]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode[0]
  input  wire logic                  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // running_id[7:0], current_tick[23:8]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // idle[0], all_done[1]
  output logic [OUT_USER_W-1:0]      m_axis_tuser_o
);

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic              best_fnd_q, best_fnd_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  entry_t            best_q, best_d;
  logic [CW-1:0]     nz_q, nz_d;

  logic                  out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [OUT_USER_W-1:0] out_user_q, out_user_d;

  logic   in_fire;
  logic   rd_issue;
  logic   finish;
  logic   load_we;
  logic   ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t ram_wdata;
  entry_t rd_entry;
  entry_t load_entry;
  entry_t wb_entry;
  logic   eligible;
  logic   better;
  logic   all_done;

  logic [ENTRY_W-1:0] ram_rdata;

  pps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TASK_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_issue),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  assign load_entry.task_id      = s_axis_tdata_i[7:0];
  assign load_entry.arrival      = s_axis_tdata_i[23:8];
  assign load_entry.remaining    = s_axis_tdata_i[39:24];
  assign load_entry.priority_val = s_axis_tdata_i[47:40];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser_i == OP_TICK) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!rd_issue && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    rd_issue        = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
    finish          = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready_i);
  end

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign load_we = in_fire && (s_axis_tuser_i == OP_LOAD) && (cnt_q < SLOTS_C);

  // A slot competes once it has arrived and still has work left.
  assign eligible = (rd_entry.remaining != '0) && (rd_entry.arrival <= tick_q);
  assign better   = eligible && (!best_fnd_q || rd_entry.priority_val < best_q.priority_val);

  always_comb begin
    wb_entry           = best_q;
    wb_entry.remaining = best_q.remaining - BURST_W'(1);
  end

  // The picked slot is the only one whose work changes, so the table is
  // finished when no slot had work, or only the picked one had its last unit.
  assign all_done = (nz_q == '0) ||
                    ((nz_q == CW'(1)) && best_fnd_q && (best_q.remaining == BURST_W'(1)));

  // Loads and write-backs never overlap: loads happen only in the idle state.
  always_comb begin
    ram_we    = load_we || (finish && best_fnd_q);
    ram_waddr = load_we ? cnt_q[AW-1:0] : best_idx_q;
    ram_wdata = load_we ? load_entry : wb_entry;
  end

  always_comb begin
    cnt_d      = cnt_q;
    tick_d     = tick_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = rd_issue;
    pidx_d     = rd_idx_q[AW-1:0];
    best_fnd_d = best_fnd_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    nz_d       = nz_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    out_user_d = out_user_q;

    if (load_we) begin
      cnt_d = cnt_q + CW'(1);
    end

    if (in_fire && s_axis_tuser_i == OP_TICK) begin
      rd_idx_d   = '0;
      best_fnd_d = 1'b0;
      nz_d       = '0;
    end

    if (rd_issue) begin
      rd_idx_d = rd_idx_q + CW'(1);
    end

    if (pend_q) begin
      if (rd_entry.remaining != '0) begin
        nz_d = nz_q + CW'(1);
      end
      if (better) begin
        best_fnd_d = 1'b1;
        best_idx_d = pidx_q;
        best_d     = rd_entry;
      end
    end

    if (finish) begin
      out_vld_d  = 1'b1;
      out_data_d = {tick_q, best_fnd_q ? best_q.task_id : ID_W'(0)};
      out_user_d = {all_done, !best_fnd_q};
      if (tick_q != TICK_MAX) begin
        tick_d = tick_q + TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      tick_q     <= '0;
      rd_idx_q   <= '0;
      pend_q     <= 1'b0;
      best_fnd_q <= 1'b0;
      nz_q       <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      tick_q     <= tick_d;
      rd_idx_q   <= rd_idx_d;
      pend_q     <= pend_d;
      best_fnd_q <= best_fnd_d;
      nz_q       <= nz_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // The load count never passes the number of slots.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOTS_C)
    else $error("load count exceeds slot count");

  // Slots with work left are counted among loaded slots only.
  a_nz_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nz_q <= cnt_q)
    else $error("busy slot count exceeds load count");

  // The tick counter only moves forward.
  a_tick_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> tick_q >= $past(tick_q))
    else $error("tick counter went backward");

  // An idle result reports id zero.
  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_user_q[0] |-> out_data_q[ID_W-1:0] == '0)
    else $error("idle result carries a task id");

endmodule

`default_nettype wire
